[src/ccsw_pkg.sv]
// Shared types, command codes and calendar helpers for the clock/calendar/stopwatch unit.
package ccsw_pkg;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_SET      = 3'd1,
      CMD_SW_START = 3'd2,
      CMD_SW_STOP  = 3'd3,
      CMD_SW_CLEAR = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } set_type;

   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [3:0] tenth;
   } clock_type;

   typedef struct packed {
      logic [6:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [3:0] tenth;
      logic       running;
   } sw_type;

   localparam logic [3:0] MONTH_MIN = 4'd1;
   localparam logic [3:0] MONTH_MAX = 4'd12;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [4:0] DAY_MIN   = 5'd1;
   localparam logic [4:0] DAY_LEAP  = 5'd29;
   localparam logic [4:0] HOUR_MAX  = 5'd23;
   localparam logic [5:0] MIN_MAX   = 6'd59;
   localparam logic [5:0] SEC_MAX   = 6'd59;
   localparam logic [3:0] TENTH_MAX = 4'd9;
   localparam logic [6:0] SW_HOUR_MAX = 7'd98;

   localparam logic [4:0] MONTH_DAYS [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Length of a month; an invalid month reads as January.
   function automatic logic [4:0] days_in(input logic [3:0] month, input logic [7:0] year);
      logic [3:0] m;
      logic [3:0] idx;
      m = (month >= MONTH_MIN && month <= MONTH_MAX) ? month : MONTH_MIN;
      idx = m - 4'd1;
      if (m == MONTH_FEB && year[1:0] == 2'b00) begin
         days_in = DAY_LEAP;
      end else begin
         days_in = MONTH_DAYS[idx];
      end
   endfunction

endpackage

[src/clock_calendar_stopwatch_unit.sv]
// A request beat passes the input register, then the result register, to its response beat.
// Throughput: one command per cycle without rsp_stall; the counter update is a single pass
// between the request register and the response register, so the state never stalls the pipe.
// Reset (synchronous, active high) sets 2000-01-01 00:00:00.0, clears and stops the
// stopwatch, and empties both pipeline registers.
module clock_calendar_stopwatch_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_set_year,
   input  logic [3:0] req_set_month,
   input  logic [4:0] req_set_day,
   input  logic [4:0] req_set_hour,
   input  logic [5:0] req_set_minute,
   input  logic [5:0] req_set_second,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_year,
   output logic [3:0] rsp_month,
   output logic [4:0] rsp_day,
   output logic [4:0] rsp_hour,
   output logic [5:0] rsp_minute,
   output logic [5:0] rsp_second,
   output logic [3:0] rsp_tenth,
   output logic [6:0] rsp_sw_hour,
   output logic [5:0] rsp_sw_minute,
   output logic [5:0] rsp_sw_second,
   output logic [3:0] rsp_sw_tenth,
   output logic       rsp_sw_running
);
   import ccsw_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   cmd_type   cmd_ff;
   set_type   set_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   clock_type clk_res_ff;
   sw_type    sw_res_ff;
   clock_type clk_next;
   sw_type    sw_next;
   logic      req_take;
   logic      advance;

   // Move the held beat forward when the response register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff        <= cmd_type'(req_cmd);
         set_ff.year   <= req_set_year;
         set_ff.month  <= req_set_month;
         set_ff.day    <= req_set_day;
         set_ff.hour   <= req_set_hour;
         set_ff.minute <= req_set_minute;
         set_ff.second <= req_set_second;
      end
      if (advance) begin
         clk_res_ff <= clk_next;
         sw_res_ff  <= sw_next;
      end
   end

   ccsw_clock u_clock (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cmd      (cmd_ff),
      .set_val  (set_ff),
      .next_val (clk_next)
   );

   ccsw_stopwatch u_stopwatch (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cmd      (cmd_ff),
      .next_val (sw_next)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_year       = clk_res_ff.year;
   assign rsp_month      = clk_res_ff.month;
   assign rsp_day        = clk_res_ff.day;
   assign rsp_hour       = clk_res_ff.hour;
   assign rsp_minute     = clk_res_ff.minute;
   assign rsp_second     = clk_res_ff.second;
   assign rsp_tenth      = clk_res_ff.tenth;
   assign rsp_sw_hour    = sw_res_ff.hour;
   assign rsp_sw_minute  = sw_res_ff.minute;
   assign rsp_sw_second  = sw_res_ff.second;
   assign rsp_sw_tenth   = sw_res_ff.tenth;
   assign rsp_sw_running = sw_res_ff.running;

endmodule

[src/ccsw_clock.sv]
// Time-of-day and calendar counters with set and tick handling.
module ccsw_clock (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ccsw_pkg::cmd_type  cmd,
   input  ccsw_pkg::set_type  set_val,
   output ccsw_pkg::clock_type next_val
);
   import ccsw_pkg::*;

   clock_type  state_ff;
   clock_type  tick_val;
   clock_type  load_val;
   logic [3:0] set_month;
   logic [4:0] set_dim;

   // Tick cascade
   always_comb begin
      tick_val = state_ff;
      if (state_ff.tenth != TENTH_MAX) begin
         tick_val.tenth = state_ff.tenth + 4'd1;
      end else begin
         tick_val.tenth = 4'd0;
         if (state_ff.second != SEC_MAX) begin
            tick_val.second = state_ff.second + 6'd1;
         end else begin
            tick_val.second = 6'd0;
            if (state_ff.minute != MIN_MAX) begin
               tick_val.minute = state_ff.minute + 6'd1;
            end else begin
               tick_val.minute = 6'd0;
               if (state_ff.hour != HOUR_MAX) begin
                  tick_val.hour = state_ff.hour + 5'd1;
               end else begin
                  tick_val.hour = 5'd0;
                  if (state_ff.day < days_in(state_ff.month, state_ff.year)) begin
                     tick_val.day = state_ff.day + 5'd1;
                  end else begin
                     tick_val.day = DAY_MIN;
                     if (state_ff.month < MONTH_MAX) begin
                        tick_val.month = state_ff.month + 4'd1;
                     end else begin
                        tick_val.month = MONTH_MIN;
                        tick_val.year  = state_ff.year + 8'd1;
                     end
                  end
               end
            end
         end
      end
   end

   // Saturate set values
   always_comb begin
      if (set_val.month < MONTH_MIN) begin
         set_month = MONTH_MIN;
      end else if (set_val.month > MONTH_MAX) begin
         set_month = MONTH_MAX;
      end else begin
         set_month = set_val.month;
      end
      set_dim = days_in(set_month, set_val.year);
      load_val.year  = set_val.year;
      load_val.month = set_month;
      if (set_val.day < DAY_MIN) begin
         load_val.day = DAY_MIN;
      end else if (set_val.day > set_dim) begin
         load_val.day = set_dim;
      end else begin
         load_val.day = set_val.day;
      end
      load_val.hour   = (set_val.hour > HOUR_MAX) ? HOUR_MAX : set_val.hour;
      load_val.minute = (set_val.minute > MIN_MAX) ? MIN_MAX : set_val.minute;
      load_val.second = (set_val.second > SEC_MAX) ? SEC_MAX : set_val.second;
      load_val.tenth  = 4'd0;
   end

   always_comb begin
      case (cmd)
         CMD_TICK: next_val = tick_val;
         CMD_SET:  next_val = load_val;
         default:  next_val = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.year   <= 8'd0;
         state_ff.month  <= MONTH_MIN;
         state_ff.day    <= DAY_MIN;
         state_ff.hour   <= 5'd0;
         state_ff.minute <= 6'd0;
         state_ff.second <= 6'd0;
         state_ff.tenth  <= 4'd0;
      end else if (advance) begin
         state_ff <= next_val;
      end
   end

endmodule

[src/ccsw_stopwatch.sv]
// Stopwatch counters and run flag.
module ccsw_stopwatch (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  ccsw_pkg::cmd_type cmd,
   output ccsw_pkg::sw_type  next_val
);
   import ccsw_pkg::*;

   sw_type state_ff;
   sw_type tick_val;

   always_comb begin
      tick_val = state_ff;
      if (state_ff.tenth != TENTH_MAX) begin
         tick_val.tenth = state_ff.tenth + 4'd1;
      end else begin
         tick_val.tenth = 4'd0;
         if (state_ff.second != SEC_MAX) begin
            tick_val.second = state_ff.second + 6'd1;
         end else begin
            tick_val.second = 6'd0;
            if (state_ff.minute != MIN_MAX) begin
               tick_val.minute = state_ff.minute + 6'd1;
            end else begin
               tick_val.minute = 6'd0;
               // wrap hours past 98
               tick_val.hour = (state_ff.hour >= SW_HOUR_MAX) ? 7'd0 : state_ff.hour + 7'd1;
            end
         end
      end
   end

   always_comb begin
      next_val = state_ff;
      case (cmd)
         CMD_TICK: begin
            if (state_ff.running) begin
               next_val = tick_val;
            end
         end
         CMD_SW_START: next_val.running = 1'b1;
         CMD_SW_STOP:  next_val.running = 1'b0;
         CMD_SW_CLEAR: begin
            next_val.hour   = 7'd0;
            next_val.minute = 6'd0;
            next_val.second = 6'd0;
            next_val.tenth  = 4'd0;
         end
         default: next_val = state_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= next_val;
      end
   end

endmodule

[tb/sv/clock_calendar_stopwatch_checker.sv]
// Checker for the clock/calendar/stopwatch unit: tracks commands, predicts readouts, compares.
`timescale 1ns / 100ps

module clock_calendar_stopwatch_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_set_year,
   input  logic [3:0] req_set_month,
   input  logic [4:0] req_set_day,
   input  logic [4:0] req_set_hour,
   input  logic [5:0] req_set_minute,
   input  logic [5:0] req_set_second,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_year,
   input  logic [3:0] rsp_month,
   input  logic [4:0] rsp_day,
   input  logic [4:0] rsp_hour,
   input  logic [5:0] rsp_minute,
   input  logic [5:0] rsp_second,
   input  logic [3:0] rsp_tenth,
   input  logic [6:0] rsp_sw_hour,
   input  logic [5:0] rsp_sw_minute,
   input  logic [5:0] rsp_sw_second,
   input  logic [3:0] rsp_sw_tenth,
   input  logic       rsp_sw_running,
   input  logic       stim_done,
   output int         error_count,
   output int         expected_left
);
   import ccsw_pkg::*;

   typedef struct packed {
      clock_type clk;
      sw_type    sw;
   } readout_type;

   clock_type   cal;
   sw_type      watch;
   readout_type expected_readouts[$];
   int          rsp_beats;
   bit          leftover_checked;

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("beat %0d: %s is %0d, want %0d", rsp_beats, name, got, want));
   endtask

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic [7:0] year);
      case (month)
         MONTH_FEB:             return (year[1:0] == 2'b00) ? DAY_LEAP : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
         default:               return 5'd31;
      endcase
   endfunction

   // One tenth of a second through the whole clock and calendar cascade.
   task automatic tick_clock();
      if (cal.tenth != TENTH_MAX) begin
         cal.tenth = cal.tenth + 4'd1;
         return;
      end
      cal.tenth = 4'd0;
      if (cal.second != SEC_MAX) begin
         cal.second = cal.second + 6'd1;
         return;
      end
      cal.second = 6'd0;
      if (cal.minute != MIN_MAX) begin
         cal.minute = cal.minute + 6'd1;
         return;
      end
      cal.minute = 6'd0;
      if (cal.hour != HOUR_MAX) begin
         cal.hour = cal.hour + 5'd1;
         return;
      end
      cal.hour = 5'd0;
      if (cal.day != month_length(cal.month, cal.year)) begin
         cal.day = cal.day + 5'd1;
         return;
      end
      cal.day = DAY_MIN;
      if (cal.month != MONTH_MAX) begin
         cal.month = cal.month + 4'd1;
         return;
      end
      cal.month = MONTH_MIN;
      cal.year  = cal.year + 8'd1;
   endtask

   task automatic tick_stopwatch();
      if (watch.tenth != TENTH_MAX) begin
         watch.tenth = watch.tenth + 4'd1;
         return;
      end
      watch.tenth = 4'd0;
      if (watch.second != SEC_MAX) begin
         watch.second = watch.second + 6'd1;
         return;
      end
      watch.second = 6'd0;
      if (watch.minute != MIN_MAX) begin
         watch.minute = watch.minute + 6'd1;
         return;
      end
      watch.minute = 6'd0;
      watch.hour = (watch.hour == SW_HOUR_MAX) ? 7'd0 : watch.hour + 7'd1;
   endtask

   task automatic apply_command(input logic [2:0] cmd, output readout_type reading);
      logic [3:0] mo;
      logic [4:0] dy;
      logic [4:0] len;
      logic       run;
      case (cmd)
         CMD_TICK: begin
            run = watch.running;
            tick_clock();
            if (run) tick_stopwatch();
         end
         CMD_SET: begin
            mo = req_set_month;
            if (mo < MONTH_MIN) mo = MONTH_MIN;
            else if (mo > MONTH_MAX) mo = MONTH_MAX;
            len = month_length(mo, req_set_year);
            dy = req_set_day;
            if (dy < DAY_MIN) dy = DAY_MIN;
            else if (dy > len) dy = len;
            cal.year   = req_set_year;
            cal.month  = mo;
            cal.day    = dy;
            cal.hour   = (req_set_hour > HOUR_MAX) ? HOUR_MAX : req_set_hour;
            cal.minute = (req_set_minute > MIN_MAX) ? MIN_MAX : req_set_minute;
            cal.second = (req_set_second > SEC_MAX) ? SEC_MAX : req_set_second;
            cal.tenth  = 4'd0;
         end
         CMD_SW_START: watch.running = 1'b1;
         CMD_SW_STOP:  watch.running = 1'b0;
         CMD_SW_CLEAR: begin
            // keep the running flag as it is
            watch.hour   = 7'd0;
            watch.minute = 6'd0;
            watch.second = 6'd0;
            watch.tenth  = 4'd0;
         end
         default: ;
      endcase
      reading.clk = cal;
      reading.sw  = watch;
   endtask

   always @(posedge clock) begin
      readout_type want;
      readout_type fresh;
      if (reset) begin
         cal   = '{year: 8'd0, month: MONTH_MIN, day: DAY_MIN, hour: 5'd0,
                   minute: 6'd0, second: 6'd0, tenth: 4'd0};
         watch = '0;
         expected_readouts.delete();
         rsp_beats = 0;
      end else begin
         // retire the response first so a beat can never match its own command
         if (rsp_valid && !rsp_stall) begin
            if (expected_readouts.size() == 0) begin
               report_error($sformatf("beat %0d: response with no command outstanding",
                                      rsp_beats));
            end else begin
               want = expected_readouts.pop_front();
               compare_field("year",       rsp_year,           want.clk.year);
               compare_field("month",      8'(rsp_month),      8'(want.clk.month));
               compare_field("day",        8'(rsp_day),        8'(want.clk.day));
               compare_field("hour",       8'(rsp_hour),       8'(want.clk.hour));
               compare_field("minute",     8'(rsp_minute),     8'(want.clk.minute));
               compare_field("second",     8'(rsp_second),     8'(want.clk.second));
               compare_field("tenth",      8'(rsp_tenth),      8'(want.clk.tenth));
               compare_field("sw_hour",    8'(rsp_sw_hour),    8'(want.sw.hour));
               compare_field("sw_minute",  8'(rsp_sw_minute),  8'(want.sw.minute));
               compare_field("sw_second",  8'(rsp_sw_second),  8'(want.sw.second));
               compare_field("sw_tenth",   8'(rsp_sw_tenth),   8'(want.sw.tenth));
               compare_field("sw_running", 8'(rsp_sw_running), 8'(want.sw.running));
            end
            rsp_beats++;
         end
         if (req_valid && !req_stall) begin
            apply_command(req_cmd, fresh);
            expected_readouts.push_back(fresh);
         end
         if (stim_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_readouts.size() != 0)
               report_error($sformatf("%0d readouts never arrived", expected_readouts.size()));
         end
      end
      expected_left = expected_readouts.size();
   end

endmodule

[tb/sv/clock_calendar_stopwatch_unit_test.sv]
// Top of the clock/calendar/stopwatch testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module clock_calendar_stopwatch_unit_test;
   import ccsw_pkg::*;

   localparam int         TOTAL_ITEMS   = 1800;
   localparam int         IDLE_LIMIT    = 2000;
   localparam int         SQUEEZE_AT    = 300;
   localparam int         SQUEEZE_LEN   = 80;
   localparam int         CALM_FIRST    = 700;
   localparam int         CALM_LAST     = 1000;
   localparam logic [2:0] CMD_RSVD_LOW  = 3'd5;
   localparam logic [2:0] CMD_RSVD_HIGH = 3'd7;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_cmd;
   logic [7:0] req_set_year;
   logic [3:0] req_set_month;
   logic [4:0] req_set_day;
   logic [4:0] req_set_hour;
   logic [5:0] req_set_minute;
   logic [5:0] req_set_second;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_year;
   logic [3:0] rsp_month;
   logic [4:0] rsp_day;
   logic [4:0] rsp_hour;
   logic [5:0] rsp_minute;
   logic [5:0] rsp_second;
   logic [3:0] rsp_tenth;
   logic [6:0] rsp_sw_hour;
   logic [5:0] rsp_sw_minute;
   logic [5:0] rsp_sw_second;
   logic [3:0] rsp_sw_tenth;
   logic       rsp_sw_running;
   logic       stim_done;
   int         error_count;
   int         expected_left;
   int         items_sent;
   int         quiet_cycles;
   bit         calm;

   clock_calendar_stopwatch_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_set_year   (req_set_year),
      .req_set_month  (req_set_month),
      .req_set_day    (req_set_day),
      .req_set_hour   (req_set_hour),
      .req_set_minute (req_set_minute),
      .req_set_second (req_set_second),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_year       (rsp_year),
      .rsp_month      (rsp_month),
      .rsp_day        (rsp_day),
      .rsp_hour       (rsp_hour),
      .rsp_minute     (rsp_minute),
      .rsp_second     (rsp_second),
      .rsp_tenth      (rsp_tenth),
      .rsp_sw_hour    (rsp_sw_hour),
      .rsp_sw_minute  (rsp_sw_minute),
      .rsp_sw_second  (rsp_sw_second),
      .rsp_sw_tenth   (rsp_sw_tenth),
      .rsp_sw_running (rsp_sw_running)
   );

   clock_calendar_stopwatch_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_set_year   (req_set_year),
      .req_set_month  (req_set_month),
      .req_set_day    (req_set_day),
      .req_set_hour   (req_set_hour),
      .req_set_minute (req_set_minute),
      .req_set_second (req_set_second),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_year       (rsp_year),
      .rsp_month      (rsp_month),
      .rsp_day        (rsp_day),
      .rsp_hour       (rsp_hour),
      .rsp_minute     (rsp_minute),
      .rsp_second     (rsp_second),
      .rsp_tenth      (rsp_tenth),
      .rsp_sw_hour    (rsp_sw_hour),
      .rsp_sw_minute  (rsp_sw_minute),
      .rsp_sw_second  (rsp_sw_second),
      .rsp_sw_tenth   (rsp_sw_tenth),
      .rsp_sw_running (rsp_sw_running),
      .stim_done      (stim_done),
      .error_count    (error_count),
      .expected_left  (expected_left)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic set_type random_load();
      set_type ld;
      ld.year   = 8'($urandom);
      ld.month  = 4'($urandom);
      ld.day    = 5'($urandom);
      ld.hour   = 5'($urandom);
      ld.minute = 6'($urandom);
      ld.second = 6'($urandom);
      return ld;
   endfunction

   // Drive one command beat at the falling edge and hold it until accepted.
   task automatic offer(input logic [2:0] cmd, input set_type ld);
      while (!calm && $urandom_range(0, 99) < 18) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_cmd        = cmd;
      req_set_year   = ld.year;
      req_set_month  = ld.month;
      req_set_day    = ld.day;
      req_set_hour   = ld.hour;
      req_set_minute = ld.minute;
      req_set_second = ld.second;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
      @(negedge clock);
   endtask

   task automatic control(input logic [2:0] cmd);
      offer(cmd, random_load());
   endtask

   task automatic ticks(input int n);
      repeat (n) control(CMD_TICK);
   endtask

   task automatic load_time(input logic [7:0] y, input logic [3:0] mo, input logic [4:0] d,
                            input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
      offer(CMD_SET, {y, mo, d, h, mi, s});
   endtask

   initial begin : stimulus
      int      roll;
      int      pick;
      set_type ld;
      reset          = 1'b1;
      stim_done      = 1'b0;
      items_sent     = 0;
      calm           = 1'b0;
      req_valid      = 1'b0;
      req_cmd        = CMD_TICK;
      req_set_year   = '0;
      req_set_month  = '0;
      req_set_day    = '0;
      req_set_hour   = '0;
      req_set_minute = '0;
      req_set_second = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // undefined codes leave everything alone
      control(CMD_RSVD_LOW);
      control(CMD_RSVD_HIGH);
      // stopwatch controls, including repeats that must do nothing
      control(CMD_SW_START);
      control(CMD_SW_START);
      control(CMD_TICK);
      control(CMD_SW_STOP);
      control(CMD_SW_STOP);
      control(CMD_TICK);
      control(CMD_SW_CLEAR);
      control(CMD_SW_START);
      // last second of the last year rolls the whole calendar over
      load_time(8'd255, MONTH_MAX, 5'd31, HOUR_MAX, MIN_MAX, SEC_MAX);
      ticks(10);
      control(CMD_SW_CLEAR);
      // saturation of out-of-range loads
      load_time(8'd0, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63);
      load_time(8'd3, MONTH_FEB, 5'd31, 5'd0, 6'd0, 6'd0);
      load_time(8'd4, MONTH_FEB, 5'd31, 5'd0, 6'd0, 6'd0);
      load_time(8'd1, 4'd15, 5'd31, 5'd24, 6'd60, 6'd60);
      load_time(8'd1, 4'd4, 5'd31, 5'd12, 6'd30, 6'd30);

      while (items_sent < TOTAL_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            // land just before a minute boundary, mostly at the end of a day, then run over it
            ld = random_load();
            ld.second = SEC_MAX;
            if ($urandom_range(0, 3) != 0) begin
               ld.minute = MIN_MAX;
               ld.hour   = HOUR_MAX;
            end
            ld.day = 5'($urandom_range(26, 31));
            pick = $urandom_range(0, 3);
            if (pick == 0) ld.month = MONTH_MAX;
            else if (pick == 1) ld.month = MONTH_FEB;
            offer(CMD_SET, ld);
            ticks($urandom_range(10, 25));
         end else if (roll < 80) begin
            ticks($urandom_range(1, 40));
         end else if (roll < 90) begin
            pick = $urandom_range(0, 5);
            if (pick < 3) control(CMD_SW_START);
            else if (pick < 5) control(CMD_SW_STOP);
            else control(CMD_SW_CLEAR);
         end else begin
            offer(3'($urandom_range(0, 7)), random_load());
         end
      end
      req_valid = 1'b0;

      while (expected_left != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      stim_done = 1'b1;
      repeat (2) @(negedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : receiver
      bit squeezed;
      squeezed  = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!squeezed && items_sent >= SQUEEZE_AT) begin
            // hold off long enough for the pipe to fill and back up into the request side
            squeezed  = 1'b1;
            rsp_stall = 1'b1;
            repeat (SQUEEZE_LEN) @(negedge clock);
         end else begin
            rsp_stall = !calm && ($urandom_range(0, 99) < 18);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

[files.f]
src/ccsw_pkg.sv
src/ccsw_clock.sv
src/ccsw_stopwatch.sv
src/clock_calendar_stopwatch_unit.sv
tb/sv/clock_calendar_stopwatch_checker.sv
tb/sv/clock_calendar_stopwatch_unit_test.sv
